// ===== rtl/lgen_pkg.sv =====
// ----------------------------------------------------------------------------
// lgen_pkg
// Shared types and constants of the Life generation core.
// ----------------------------------------------------------------------------
package lgen_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RESET_SIZE     = 1024;

    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 1;
    localparam int POS_W    = 10;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0]        BIRTH_COUNT   = 4'd3;
    localparam logic [3:0]        SURVIVE_COUNT = 4'd2;
    localparam logic [BYTE_W-1:0] LEVEL_ALIVE   = 8'd0;
    localparam logic [BYTE_W-1:0] LEVEL_DEAD    = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic inner;
        logic row_end;
        logic last_row;
    } lgen_emit_t;

    typedef struct packed {
        lgen_emit_t emit;
        logic       interior;
        logic       cur;
    } lgen_flags_t;

endpackage

// ===== rtl/lgen_if.sv =====
// ----------------------------------------------------------------------------
// lgen_if
// Handshake channels of the Life generation core.
// ----------------------------------------------------------------------------
interface lgen_pixel_if import lgen_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] blue_byte;
    logic [BYTE_W-1:0] green_byte;
    logic [BYTE_W-1:0] red_byte;

    modport source (output valid, blue_byte, green_byte, red_byte, input ready);
    modport sink   (input valid, blue_byte, green_byte, red_byte, output ready);
endinterface

interface lgen_cell_if import lgen_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  cell_row;
    logic [POS_W-1:0]  cell_col;
    logic              alive_next;
    logic [BYTE_W-1:0] pixel_level;
    logic              last_of_run;

    modport source (output valid, cell_row, cell_col, alive_next, pixel_level, last_of_run,
                    input ready);
    modport sink   (input valid, cell_row, cell_col, alive_next, pixel_level, last_of_run,
                    output ready);
endinterface

interface lgen_cfg_if import lgen_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lgen_front.sv =====
// ----------------------------------------------------------------------------
// lgen_front
// Frame size registers, raster position and per-item classification.
// ----------------------------------------------------------------------------
module lgen_front import lgen_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lgen_cfg_if.sink                      cfg,
    lgen_pixel_if.sink                    pixel,
    input  logic                          queue_ready,
    output logic                          push,
    output lgen_flags_t                   job_flags,
    output logic [$clog2(MAX_HEIGHT)-1:0] job_row,
    output logic [$clog2(MAX_WIDTH)-1:0]  job_col
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SWW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int SWH = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
    localparam int W_RST = (RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_SIZE;
    localparam int H_RST = (RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RESET_SIZE;

    logic [CW-1:0]  wlast_reg;
    logic [RW-1:0]  hlast_reg;
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [SWW-1:0] cfg_w;
    logic [SWH-1:0] cfg_h;
    logic [CW-1:0]  wlast_cand;
    logic [RW-1:0]  hlast_cand;
    logic [CW-1:0]  c;
    logic [RW-1:0]  r;

    assign cfg.ready = 1'b1;
    assign cfg_w     = SWW'(cfg.data);
    assign cfg_h     = SWH'(cfg.data);

    always_comb
    begin
        if (cfg_w == '0)
        begin
            wlast_cand = '0;
        end
        else if (cfg_w > SWW'(MAX_WIDTH))
        begin
            wlast_cand = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wlast_cand = CW'(cfg_w - SWW'(1));
        end
        if (cfg_h == '0)
        begin
            hlast_cand = '0;
        end
        else if (cfg_h > SWH'(MAX_HEIGHT))
        begin
            hlast_cand = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            hlast_cand = RW'(cfg_h - SWH'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg <= CW'(W_RST - 1);
            hlast_reg <= RW'(H_RST - 1);
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_FRAME_WIDTH:  wlast_reg <= wlast_cand;
                REG_FRAME_HEIGHT: hlast_reg <= hlast_cand;
            endcase
        end
    end

    // wrap a position left beyond a shrunken frame
    assign c = (col_reg > wlast_reg) ? '0 : col_reg;
    assign r = (row_reg > hlast_reg) ? '0 : row_reg;

    assign pixel.ready = queue_ready;
    assign push        = pixel.valid && queue_ready;

    always_comb
    begin
        job_flags.emit.inner    = (r != '0) && (c != '0);
        job_flags.emit.row_end  = (r != '0) && (c == wlast_reg);
        job_flags.emit.last_row = (r == hlast_reg);
        job_flags.interior      = (r > RW'(1)) && (c > CW'(1));
        job_flags.cur           = |{pixel.blue_byte, pixel.green_byte, pixel.red_byte};
        job_row                 = r;
        job_col                 = c;
    end

    always_comb
    begin
        if (c == wlast_reg)
        begin
            col_next = '0;
            row_next = (r == hlast_reg) ? '0 : RW'(r + RW'(1));
        end
        else
        begin
            col_next = CW'(c + CW'(1));
            row_next = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/lgen_queue.sv =====
// ----------------------------------------------------------------------------
// lgen_queue
// Short register queue between the classifying front and the compute back.
// ----------------------------------------------------------------------------
module lgen_queue import lgen_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              ready,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]     count_reg;

    assign ready      = (count_reg != NW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + PW'(1));
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + PW'(1));
            end
            if (push && !pop)
            begin
                count_reg <= NW'(count_reg + NW'(1));
            end
            else if (pop && !push)
            begin
                count_reg <= NW'(count_reg - NW'(1));
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== rtl/lgen_back.sv =====
// ----------------------------------------------------------------------------
// lgen_back
// Line stores, 3x3 window, B3/S23 rule and result sequencing.
// ----------------------------------------------------------------------------
module lgen_back import lgen_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  lgen_flags_t                   head_flags,
    input  logic [$clog2(MAX_HEIGHT)-1:0] head_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]  head_col,
    output logic                          pop,
    lgen_cell_if.source                   result
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic upper_mem  [MAX_WIDTH];
    logic middle_mem [MAX_WIDTH];

    logic        b2_valid_reg;
    lgen_flags_t b2_flags_reg;
    logic [RW-1:0] b2_row_reg;
    logic [CW-1:0] b2_col_reg;
    logic        up_rd_reg, mid_rd_reg;
    logic        byp_reg, byp_up_reg, byp_mid_reg;
    lgen_emit_t  sent_reg;
    logic [8:0]  window_reg;

    logic        out_valid_reg;
    logic [POS_W-1:0]  out_row_reg, out_col_reg;
    logic        out_alive_reg, out_last_reg;

    logic        up, mid, center;
    logic [8:0]  window_next;
    logic [3:0]  live_count, nbr;
    logic        alive_inner;
    lgen_emit_t  pending, sel;
    logic        last_sel, out_can_load, fire, done;
    logic [RW-1:0] res_row;
    logic [CW-1:0] res_col;
    logic        res_alive;

    assign up     = byp_reg ? byp_up_reg  : up_rd_reg;
    assign mid    = byp_reg ? byp_mid_reg : mid_rd_reg;
    assign center = window_reg[3];

    assign window_next = {window_reg[7:6], up, window_reg[4:3], mid,
                          window_reg[1:0], b2_flags_reg.cur};

    always_comb
    begin
        live_count = '0;
        for (int i = 0; i < 9; i++)
        begin
            live_count = live_count + 4'(window_next[i]);
        end
        nbr = live_count - 4'(center);
    end

    always_comb
    begin
        if (b2_flags_reg.interior)
        begin
            alive_inner = (nbr == BIRTH_COUNT) || (center && (nbr == SURVIVE_COUNT));
        end
        else
        begin
            alive_inner = center;
        end
    end

    assign pending = b2_flags_reg.emit & ~sent_reg;

    always_comb
    begin
        sel       = '0;
        res_row   = b2_row_reg;
        res_col   = b2_col_reg;
        res_alive = b2_flags_reg.cur;
        priority if (pending.inner)
        begin
            sel.inner = 1'b1;
            res_row   = RW'(b2_row_reg - RW'(1));
            res_col   = CW'(b2_col_reg - CW'(1));
            res_alive = alive_inner;
        end
        else if (pending.row_end)
        begin
            sel.row_end = 1'b1;
            res_row     = RW'(b2_row_reg - RW'(1));
            res_alive   = mid;
        end
        else if (pending.last_row)
        begin
            sel.last_row = 1'b1;
        end
        else
        begin
            sel = '0;
        end
    end

    assign last_sel     = ((pending & ~sel) == '0);
    assign out_can_load = !out_valid_reg || result.ready;
    assign fire         = b2_valid_reg && (pending != '0) && out_can_load;
    assign done         = b2_valid_reg && ((pending == '0) || (fire && last_sel));
    assign pop          = head_valid && (!b2_valid_reg || done);

    // line stores: read on pop, written when the held item retires
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            upper_mem[b2_col_reg]  <= mid;
            middle_mem[b2_col_reg] <= b2_flags_reg.cur;
        end
        if (pop)
        begin
            up_rd_reg  <= upper_mem[head_col];
            mid_rd_reg <= middle_mem[head_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b2_flags_reg <= head_flags;
            b2_row_reg   <= head_row;
            b2_col_reg   <= head_col;
            byp_up_reg   <= mid;
            byp_mid_reg  <= b2_flags_reg.cur;
        end
        if (fire)
        begin
            out_row_reg   <= POS_W'(res_row);
            out_col_reg   <= POS_W'(res_col);
            out_alive_reg <= res_alive;
            out_last_reg  <= last_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg  <= 1'b0;
            byp_reg       <= 1'b0;
            sent_reg      <= '0;
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                b2_valid_reg <= 1'b1;
                byp_reg      <= done && (head_col == b2_col_reg);
                sent_reg     <= '0;
            end
            else
            begin
                if (done)
                begin
                    b2_valid_reg <= 1'b0;
                end
                if (fire && !last_sel)
                begin
                    sent_reg <= sent_reg | sel;
                end
            end
            if (done)
            begin
                window_reg <= window_next;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.cell_row    = out_row_reg;
    assign result.cell_col    = out_col_reg;
    assign result.alive_next  = out_alive_reg;
    assign result.pixel_level = out_alive_reg ? LEVEL_ALIVE : LEVEL_DEAD;
    assign result.last_of_run = out_last_reg;

    a_sent_subset: assert property (@(posedge clk) disable iff (!rst_n)
        b2_valid_reg |-> ((sent_reg & ~b2_flags_reg.emit) == '0))
        else $error("result sent that the item does not call for");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (b2_valid_reg && (pending != '0) && !out_can_load) |=> b2_valid_reg)
        else $error("item dropped while results pending");

    a_retire_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_sel) |=> (!b2_valid_reg || (sent_reg == '0)))
        else $error("stale sent mask after item retired");

endmodule

// ===== rtl/life_automaton_generation_core.sv =====
// ----------------------------------------------------------------------------
// life_automaton_generation_core
// One Game of Life (B3/S23) generation over a streamed raster frame.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : register writes (index 0 frame width, 1 frame height), always
//            ready; write only while the core is idle.
//   pixel  : one RGB item per accepted handshake, raster order, top row
//            first. A cell is alive if any byte is nonzero.
//   result : next-generation cells with coordinates; last_of_run marks the
//            final result of an input item. Each item yields zero to three.
// Path: an accepted item passes through the queue, then the line store
//   read, then the result register, before its first result is valid.
// Throughput: one item per cycle while items give at most one result and the
//   receiver is ready; an item with more results stays in compute until the
//   single result register has taken each. A 4-entry queue absorbs the lag.
// Reset: sizes return to 1024 (clamped to the maximum), position to (0,0),
//   window to zero; line stores are not cleared.
// Stall: a stalled receiver holds the result register; the queue fills and
//   then pixel.ready drops.
// ----------------------------------------------------------------------------
module life_automaton_generation_core import lgen_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic         clk,
    input  logic         rst_n,
    lgen_cfg_if.sink     cfg,
    lgen_pixel_if.sink   pixel,
    lgen_cell_if.source  result
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int FLAG_W = $bits(lgen_flags_t);
    localparam int JOB_W  = FLAG_W + RW + CW;

    logic              push, pop, queue_ready, head_valid;
    lgen_flags_t       job_flags, head_flags;
    logic [RW-1:0]     job_row, head_row;
    logic [CW-1:0]     job_col, head_col;
    logic [JOB_W-1:0]  head_data;

    lgen_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pixel       (pixel),
        .queue_ready (queue_ready),
        .push        (push),
        .job_flags   (job_flags),
        .job_row     (job_row),
        .job_col     (job_col)
    );

    lgen_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({job_flags, job_row, job_col}),
        .ready      (queue_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign {head_flags, head_row, head_col} = head_data;

    lgen_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_flags (head_flags),
        .head_row   (head_row),
        .head_col   (head_col),
        .pop        (pop),
        .result     (result)
    );

endmodule
